@@ sv/csrd_pkg.sv @@
// Shared types, constants and the microprogram for the coordinate-seeded draw block.
// Used by csrd_seq, csrd_dp, csrd_div and coordinate_seeded_random_draw.
package csrd_pkg;

  localparam logic [63:0] MIX_MUL = 64'h5851_F42D_4C95_7F2D;
  localparam logic [63:0] MIX_ADD = 64'h1405_7B7E_F767_814F;
  localparam int DRAW_SHIFT = 24;
  localparam int MAG_W = 64 - DRAW_SHIFT;
  localparam int STEP_W = $clog2(MAG_W);
  localparam int PC_W = 5;
  localparam int CNT_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_SALT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORLD_SEED = 2'd1;

  localparam logic MODE_SEED = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  localparam logic [PC_W-1:0] PC_ROUND  = 5'd0;
  localparam logic [PC_W-1:0] PC_DERIVE = 5'd12;
  localparam logic [PC_W-1:0] PC_POS    = 5'd19;
  localparam logic [PC_W-1:0] PC_DRAW   = 5'd24;
  localparam logic [PC_W-1:0] PC_LAST   = 5'd26;

  typedef enum logic [1:0] {
    ASEL_R_LO = 2'd0,
    ASEL_R_HI = 2'd1,
    ASEL_T_LO = 2'd2,
    ASEL_T_HI = 2'd3
  } asel_t;

  typedef enum logic [1:0] {
    BSEL_K_LO = 2'd0,
    BSEL_K_HI = 2'd1,
    BSEL_R_LO = 2'd2,
    BSEL_R_HI = 2'd3
  } bsel_t;

  typedef enum logic [2:0] {
    ACC_NONE   = 3'd0,
    ACC_LOAD   = 3'd1,
    ACC_ADD_HI = 3'd2,
    ACC_ADD_C  = 3'd3,
    ACC_ADD_V  = 3'd4
  } acc_op_t;

  typedef enum logic [2:0] {
    RSRC_HOLD  = 3'd0,
    RSRC_Q     = 3'd1,
    RSRC_SALT  = 3'd2,
    RSRC_WORLD = 3'd3,
    RSRC_LAYER = 3'd4,
    RSRC_GEN   = 3'd5
  } rsrc_t;

  typedef enum logic [2:0] {
    VSEL_SALT  = 3'd0,
    VSEL_MIXED = 3'd1,
    VSEL_X     = 3'd2,
    VSEL_Y     = 3'd3,
    VSEL_LAYER = 3'd4
  } vsel_t;

  typedef enum logic [2:0] {
    SEQ_NEXT = 3'd0,
    SEQ_CALL = 3'd1,
    SEQ_RET  = 3'd2,
    SEQ_DJNZ = 3'd3,
    SEQ_EMIT = 3'd4,
    SEQ_DONE = 3'd5
  } seq_op_t;

  typedef struct packed {
    asel_t             a_sel;
    bsel_t             b_sel;
    acc_op_t           acc_op;
    logic              wr_t;
    rsrc_t             r_src;
    logic              st_mixed;
    logic              st_layer;
    logic              st_gen;
    logic              set_vsel;
    vsel_t             vsel;
    logic              cnt_load;
    logic [CNT_W-1:0]  cnt_val;
    seq_op_t           seq_op;
    logic [PC_W-1:0]   target;
    logic              div_start;
  } ctrl_t;

  // Microprogram. The round subroutine computes r = r*(r*A + C) + v
  // with 32x32 partial products; the other programs call it.
  function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] addr);
    ctrl_t c;
    c = '0;
    case (addr)
      PC_ROUND + 5'd0: begin
        c.a_sel = ASEL_R_LO; c.b_sel = BSEL_K_LO;
      end
      PC_ROUND + 5'd1: begin
        c.a_sel = ASEL_R_LO; c.b_sel = BSEL_K_HI; c.acc_op = ACC_LOAD;
      end
      PC_ROUND + 5'd2: begin
        c.a_sel = ASEL_R_HI; c.b_sel = BSEL_K_LO; c.acc_op = ACC_ADD_HI;
      end
      PC_ROUND + 5'd3: c.acc_op = ACC_ADD_HI;
      PC_ROUND + 5'd4: c.acc_op = ACC_ADD_C;
      PC_ROUND + 5'd5: c.wr_t = 1'b1;
      PC_ROUND + 5'd6: begin
        c.a_sel = ASEL_T_LO; c.b_sel = BSEL_R_LO;
      end
      PC_ROUND + 5'd7: begin
        c.a_sel = ASEL_T_LO; c.b_sel = BSEL_R_HI; c.acc_op = ACC_LOAD;
      end
      PC_ROUND + 5'd8: begin
        c.a_sel = ASEL_T_HI; c.b_sel = BSEL_R_LO; c.acc_op = ACC_ADD_HI;
      end
      PC_ROUND + 5'd9: c.acc_op = ACC_ADD_HI;
      PC_ROUND + 5'd10: c.acc_op = ACC_ADD_V;
      PC_ROUND + 5'd11: begin
        c.r_src = RSRC_Q; c.seq_op = SEQ_RET;
      end
      // derive mixed salt, then layer seed
      PC_DERIVE + 5'd0: begin
        c.r_src = RSRC_SALT; c.set_vsel = 1'b1; c.vsel = VSEL_SALT;
        c.cnt_load = 1'b1; c.cnt_val = 2'd3;
      end
      PC_DERIVE + 5'd1: begin
        c.seq_op = SEQ_CALL; c.target = PC_ROUND;
      end
      PC_DERIVE + 5'd2: begin
        c.seq_op = SEQ_DJNZ; c.target = PC_DERIVE + 5'd1;
      end
      PC_DERIVE + 5'd3: begin
        c.st_mixed = 1'b1; c.r_src = RSRC_WORLD;
        c.set_vsel = 1'b1; c.vsel = VSEL_MIXED;
        c.cnt_load = 1'b1; c.cnt_val = 2'd3;
      end
      PC_DERIVE + 5'd4: begin
        c.seq_op = SEQ_CALL; c.target = PC_ROUND;
      end
      PC_DERIVE + 5'd5: begin
        c.seq_op = SEQ_DJNZ; c.target = PC_DERIVE + 5'd4;
      end
      PC_DERIVE + 5'd6: begin
        c.st_layer = 1'b1; c.seq_op = SEQ_DONE;
      end
      // seed at position: rounds over x, y, x, y
      PC_POS + 5'd0: begin
        c.r_src = RSRC_LAYER; c.cnt_load = 1'b1; c.cnt_val = 2'd2;
      end
      PC_POS + 5'd1: begin
        c.set_vsel = 1'b1; c.vsel = VSEL_X;
        c.seq_op = SEQ_CALL; c.target = PC_ROUND;
      end
      PC_POS + 5'd2: begin
        c.set_vsel = 1'b1; c.vsel = VSEL_Y;
        c.seq_op = SEQ_CALL; c.target = PC_ROUND;
      end
      PC_POS + 5'd3: begin
        c.seq_op = SEQ_DJNZ; c.target = PC_POS + 5'd1;
      end
      PC_POS + 5'd4: begin
        c.st_gen = 1'b1; c.seq_op = SEQ_DONE;
      end
      // draw: divider runs on the old state while the round advances it
      PC_DRAW + 5'd0: begin
        c.r_src = RSRC_GEN; c.set_vsel = 1'b1; c.vsel = VSEL_LAYER;
        c.div_start = 1'b1;
      end
      PC_DRAW + 5'd1: begin
        c.seq_op = SEQ_CALL; c.target = PC_ROUND;
      end
      PC_DRAW + 5'd2: begin
        c.st_gen = 1'b1; c.seq_op = SEQ_EMIT;
      end
      default: c.seq_op = SEQ_DONE;
    endcase
    return c;
  endfunction

endpackage

@@ sv/csrd_seq.sv @@
// Microcode sequencer: step counter, return address, loop counter and program ROM.
// Depends on csrd_pkg for the control word and the program.
module csrd_seq
  import csrd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [PC_W-1:0] start_pc,
  input  logic            div_done,
  input  logic            out_free,
  output ctrl_t           ctrl,
  output logic            emit,
  output logic            idle
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_t;

  seq_state_t       state;
  logic [PC_W-1:0]  pc;
  logic [PC_W-1:0]  ret;
  logic [CNT_W-1:0] cnt;
  ctrl_t            word;

  assign word = ucode_rom(pc);
  assign idle = (state == ST_IDLE);
  assign ctrl = (state == ST_RUN) ? word : '0;
  assign emit = (state == ST_RUN) && (word.seq_op == SEQ_EMIT) && div_done && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;  // derive seeds from the reset register values
      pc    <= PC_DERIVE;
      ret   <= '0;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_RUN;
            pc    <= start_pc;
          end
        end
        ST_RUN: begin
          if (word.cnt_load) begin
            cnt <= word.cnt_val;
          end
          case (word.seq_op)
            SEQ_NEXT: pc <= pc + PC_W'(1);
            SEQ_CALL: begin
              ret <= pc + PC_W'(1);
              pc  <= word.target;
            end
            SEQ_RET: pc <= ret;
            SEQ_DJNZ: begin
              cnt <= cnt - CNT_W'(1);
              pc  <= (cnt != CNT_W'(1)) ? word.target : pc + PC_W'(1);
            end
            SEQ_EMIT: begin
              // hold until the remainder is ready and the output slot is free
              if (div_done && out_free) begin
                state <= ST_IDLE;
              end
            end
            SEQ_DONE: state <= ST_IDLE;
            default: state <= ST_IDLE;
          endcase
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_pc_in_program: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (pc <= PC_LAST))
    else $error("sequencer left the program");
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    (idle && start) |=> (state == ST_RUN && pc == $past(start_pc)))
    else $error("start did not launch the program");
`endif

endmodule

@@ sv/csrd_div.sv @@
// Radix-2 floor-modulo unit: one remainder bit per cycle over the shifted state.
// Depends on csrd_pkg for the shift and magnitude width.
module csrd_div
  import csrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  input  logic [30:0] bound,
  output logic        done,
  output logic [30:0] result
);

  logic [30:0]       m;
  logic              neg;
  logic [MAG_W-1:0]  dvd;
  logic [30:0]       rem;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic [MAG_W-1:0]  shifted;
  logic [MAG_W-1:0]  mag;
  logic [31:0]       rem_sh;
  logic [32:0]       diff;

  assign shifted = value[63:DRAW_SHIFT];
  assign mag     = value[63] ? (~shifted + MAG_W'(1)) : shifted;
  assign rem_sh  = {rem, dvd[MAG_W-1]};
  assign diff    = {1'b0, rem_sh} - {2'b00, m};
  // negative value: floor modulo comes from the magnitude's remainder
  assign result  = (neg && rem != '0) ? (m - rem) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && step == STEP_W'(MAG_W - 1)) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m    <= (bound == '0) ? 31'd1 : bound;
      neg  <= value[63];
      dvd  <= mag;
      rem  <= '0;
      step <= '0;
    end else if (busy) begin
      rem  <= diff[32] ? rem_sh[30:0] : diff[30:0];
      dvd  <= {dvd[MAG_W-2:0], 1'b0};
      step <= step + STEP_W'(1);
    end
  end

`ifndef ASSERT_OFF
  a_result_below_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result < m))
    else $error("draw value not below bound");
`endif

endmodule

@@ sv/csrd_dp.sv @@
// Datapath: registers, one 32x32 multiplier, the 64-bit accumulator and the seed store.
// Driven by the control word from csrd_seq; depends on csrd_pkg.
module csrd_dp
  import csrd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_t                ctrl,
  input  logic                 in_load,
  input  logic [31:0]          in_x,
  input  logic [31:0]          in_y,
  input  logic [30:0]          in_bound,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  output logic [63:0]          gen,
  output logic [30:0]          bound_q
);

  logic [63:0] salt;
  logic [63:0] world;
  logic [63:0] mixed;
  logic [63:0] layer;
  logic [63:0] r;
  logic [63:0] t;
  logic [63:0] p;
  logic [63:0] q;
  logic [31:0] x_q;
  logic [31:0] y_q;
  vsel_t       vsel_q;
  logic [31:0] a_op;
  logic [31:0] b_op;
  logic [63:0] prod;
  logic [63:0] addend;

  always_comb begin
    case (ctrl.a_sel)
      ASEL_R_LO: a_op = r[31:0];
      ASEL_R_HI: a_op = r[63:32];
      ASEL_T_LO: a_op = t[31:0];
      ASEL_T_HI: a_op = t[63:32];
      default:   a_op = '0;
    endcase
    case (ctrl.b_sel)
      BSEL_K_LO: b_op = MIX_MUL[31:0];
      BSEL_K_HI: b_op = MIX_MUL[63:32];
      BSEL_R_LO: b_op = r[31:0];
      BSEL_R_HI: b_op = r[63:32];
      default:   b_op = '0;
    endcase
    case (vsel_q)
      VSEL_SALT:  addend = salt;
      VSEL_MIXED: addend = mixed;
      VSEL_X:     addend = {{32{x_q[31]}}, x_q};
      VSEL_Y:     addend = {{32{y_q[31]}}, y_q};
      VSEL_LAYER: addend = layer;
      default:    addend = '0;
    endcase
  end

  assign prod = a_op * b_op;

  always_ff @(posedge clk) begin
    p <= prod;
    case (ctrl.acc_op)
      ACC_LOAD:   q <= p;
      ACC_ADD_HI: q <= q + {p[31:0], 32'd0};
      ACC_ADD_C:  q <= q + MIX_ADD;
      ACC_ADD_V:  q <= q + addend;
      default:    q <= q;
    endcase
    if (ctrl.wr_t) begin
      t <= q;
    end
    case (ctrl.r_src)
      RSRC_Q:     r <= q;
      RSRC_SALT:  r <= salt;
      RSRC_WORLD: r <= world;
      RSRC_LAYER: r <= layer;
      RSRC_GEN:   r <= gen;
      default:    r <= r;
    endcase
    if (ctrl.st_mixed) begin
      mixed <= r;
    end
    if (ctrl.st_layer) begin
      layer <= r;
    end
    if (ctrl.set_vsel) begin
      vsel_q <= ctrl.vsel;
    end
    if (in_load) begin
      x_q     <= in_x;
      y_q     <= in_y;
      bound_q <= in_bound;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      salt  <= '0;
      world <= '0;
      gen   <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_LAYER_SALT) begin
        salt <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_WORLD_SEED) begin
        world <= cfg_data;
      end
      if (ctrl.st_gen) begin
        gen <= r;
      end
    end
  end

endmodule

@@ sv/coordinate_seeded_random_draw.sv @@
// Coordinate-seeded pseudo-random draw block, top level with stream and config ports.
// Instantiates csrd_seq, csrd_dp and csrd_div; depends on csrd_pkg.
//
// One item is worked at a time by a microcoded sequencer driving a single 32x32
// multiplier; a mixing round is made of six partial products and adds.
// A position item (tuser 0) runs four rounds and gives no output item. A draw
// item (tuser 1) runs the one round that advances the state alongside the
// 40-step radix-2 remainder unit and finishes once that unit is done. A write
// to the salt or world seed register re-derives the mixed salt and layer seed
// in six rounds, and after reset the same derivation runs before the first item
// is taken. A finished result waits in the output register while the next item
// is accepted.
module coordinate_seeded_random_draw
  import csrd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [95:0]          s_axis_tdata,  // coord_x, coord_y, bound, zero pad
  input  logic                 s_axis_tuser,  // mode
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,  // draw_value, zero pad
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  ctrl_t           ctrl;
  logic            idle;
  logic            emit;
  logic            in_acc;
  logic            cfg_acc;
  logic            cfg_known;
  logic            start;
  logic [PC_W-1:0] start_pc;
  logic            out_free;
  logic            div_done;
  logic [30:0]     div_result;
  logic [63:0]     gen;
  logic [30:0]     bound_q;

  assign cfg_ready     = idle;
  assign s_axis_tready = idle && !cfg_valid;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_acc       = cfg_valid && cfg_ready;
  assign cfg_known     = (cfg_index == CFG_LAYER_SALT) || (cfg_index == CFG_WORLD_SEED);
  assign start         = in_acc || (cfg_acc && cfg_known);
  assign start_pc      = !in_acc ? PC_DERIVE :
                         (s_axis_tuser == MODE_DRAW) ? PC_DRAW : PC_POS;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  csrd_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .start_pc (start_pc),
    .div_done (div_done),
    .out_free (out_free),
    .ctrl     (ctrl),
    .emit     (emit),
    .idle     (idle)
  );

  csrd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .in_load   (in_acc),
    .in_x      (s_axis_tdata[31:0]),
    .in_y      (s_axis_tdata[63:32]),
    .in_bound  (s_axis_tdata[94:64]),
    .cfg_we    (cfg_acc),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gen       (gen),
    .bound_q   (bound_q)
  );

  csrd_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (ctrl.div_start),
    .value  (gen),
    .bound  (bound_q),
    .done   (div_done),
    .result (div_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= {1'b0, div_result};
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrote a waiting item");
  a_item_starts_work: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !idle)
    else $error("accepted item did not start the sequencer");
  a_cfg_rederives: assert property (@(posedge clk) disable iff (rst)
    (cfg_acc && cfg_known) |=> !idle)
    else $error("register write did not re-derive seeds");
`endif

endmodule
